>>> design/move_to_front_encoder_macros.svh
// Assertion macros used by the move-to-front encoder top level.
`ifndef MOVE_TO_FRONT_ENCODER_MACROS_SVH
`define MOVE_TO_FRONT_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MTFE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/mtfe_pkg.sv
// Shared types and constants of the move-to-front encoder.
package mtfe_pkg;

   // Fixed widths of the request and response fields.
   localparam int SYMBOL_W  = 8;
   localparam int RANK_W    = 8;
   localparam int SYM_RANGE = 1 << SYMBOL_W;

   // Control that the sequencer broadcasts to every cell.
   typedef struct packed {
      logic compare;   // Latch whether the cell holds the incoming symbol.
      logic update;    // Apply the move-to-front shift this cycle.
      logic restore;   // Return to identity order instead of shifting.
   } cell_ctrl_type;

endpackage

>>> design/move_to_front_encoder.sv
// Top level of the byte-wise move-to-front encoder.
// The ordering table is a row of ALPHABET_SIZE cells, cell i holding the symbol at
// position i; after reset, and after any request flagged last_of_block, the row is in
// identity order. Each request yields one response carrying the symbol's position
// before it moves to the front. In the accept cycle every cell compares its entry
// with the symbol and registers a match flag; in the encode state the match flags
// are encoded into the rank, the rank is registered for the response and each cell
// at or before that position takes its neighbour's entry. No new request is taken
// until the encode state is left; the response register lets the next request be
// accepted while the previous rank still waits, and the encode state waits only if
// an older response is still unread. Symbols at or above ALPHABET_SIZE are first
// reduced modulo ALPHABET_SIZE.
`include "move_to_front_encoder_macros.svh"

module move_to_front_encoder #(
   parameter int ALPHABET_SIZE = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mtfe_pkg::SYMBOL_W-1:0] req_symbol,
   input  logic                          req_last_of_block,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mtfe_pkg::RANK_W-1:0]   rsp_rank
);
   import mtfe_pkg::*;

   localparam int IDX_W = $clog2(ALPHABET_SIZE);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_ENCODE
   } state_type;

   state_type         state_ff;
   logic              rsp_valid_ff;
   logic [RANK_W-1:0] rank_ff;
   logic [IDX_W-1:0]  sym_ff;
   logic              last_ff;

   logic              req_accept;
   logic              table_update;
   logic [IDX_W-1:0]  sym_in;
   logic [IDX_W-1:0]  rank_enc;
   cell_ctrl_type     cell_ctrl;

   logic [IDX_W-1:0]         sym_mod [SYM_RANGE];
   logic [IDX_W-1:0]         entry   [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] match_vec;

   // Constant table that folds a byte into the alphabet.
   for (genvar v = 0; v < SYM_RANGE; v++) begin : g_sym_mod
      assign sym_mod[v] = IDX_W'(v % ALPHABET_SIZE);
   end

   assign sym_in       = sym_mod[req_symbol];
   assign req_ready    = (state_ff == ST_IDLE);
   assign req_accept   = req_valid && req_ready;
   assign table_update = (state_ff == ST_ENCODE) && (!rsp_valid_ff || rsp_ready);

   // Broadcast control to the cells.
   always_comb begin
      cell_ctrl.compare = req_accept;
      cell_ctrl.update  = table_update;
      cell_ctrl.restore = last_ff;
   end

   // Row of cells; cell 0 takes the symbol itself when the table shifts.
   for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
      logic [IDX_W-1:0] prev_entry;
      if (i == 0) begin : g_head
         assign prev_entry = sym_ff;
      end else begin : g_body
         assign prev_entry = entry[i-1];
      end

      mtfe_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .symbol     (sym_in),
         .rank       (rank_enc),
         .prev_entry (prev_entry),
         .entry      (entry[i]),
         .match      (match_vec[i])
      );
   end

   mtfe_rank_enc #(
      .ALPHABET_SIZE (ALPHABET_SIZE),
      .IDX_W         (IDX_W)
   ) u_rank_enc (
      .match_vec (match_vec),
      .rank      (rank_enc)
   );

   // Sequencer with the request latch and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A response is loaded on a table update and otherwise held until it is taken.
         rsp_valid_ff <= table_update || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  sym_ff   <= sym_in;
                  last_ff  <= req_last_of_block;
                  state_ff <= ST_ENCODE;
               end
            end
            ST_ENCODE: begin
               if (table_update) begin
                  rank_ff  <= RANK_W'(rank_enc);
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rank  = rank_ff;

   // The table is a permutation, so exactly one cell matches while encoding.
   `MTFE_ASSERT_NOW(a_single_match, clock, reset, state_ff == ST_ENCODE, $onehot(match_vec), "cell row does not hold exactly one copy of the symbol")
   // An accepted request is encoded next and blocks further requests meanwhile.
   `MTFE_ASSERT_NEXT(a_accept_to_encode, clock, reset, req_accept, state_ff == ST_ENCODE && !req_ready, "accepted request did not move to encode")
   // A table update always leaves a response waiting.
   `MTFE_ASSERT_NEXT(a_update_gives_rsp, clock, reset, table_update, rsp_valid_ff && state_ff == ST_IDLE, "table update without a pending response")

endmodule

>>> design/mtfe_cell.sv
// One cell of the ordering table: holds one entry and its match flag.
module mtfe_cell #(
   parameter int IDX_W = 8,
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mtfe_pkg::cell_ctrl_type ctrl,
   input  logic [IDX_W-1:0]      symbol,
   input  logic [IDX_W-1:0]      rank,
   input  logic [IDX_W-1:0]      prev_entry,
   output logic [IDX_W-1:0]      entry,
   output logic                  match
);
   import mtfe_pkg::*;

   localparam logic [IDX_W-1:0] IDENTITY = IDX_W'(INDEX);

   logic [IDX_W-1:0] entry_ff;
   logic [IDX_W-1:0] entry_in;
   logic             match_ff;

   // Next entry: identity on block end, neighbour's entry if at or before the hit.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.update) begin
         if (ctrl.restore) begin
            entry_in = IDENTITY;
         end else if (rank >= IDENTITY) begin
            entry_in = prev_entry;
         end
      end
   end

   // The entry itself is table state and returns to identity on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= IDENTITY;
      end else begin
         entry_ff <= entry_in;
      end
   end

   // Match flag is registered on a compare and held while the request is encoded.
   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         match_ff <= (entry_ff == symbol);
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

>>> design/mtfe_rank_enc.sv
// One-hot to binary encoder that turns the cells' match flags into a rank.
module mtfe_rank_enc #(
   parameter int ALPHABET_SIZE = 256,
   parameter int IDX_W         = 8
) (
   input  logic [ALPHABET_SIZE-1:0] match_vec,
   output logic [IDX_W-1:0]         rank
);
   import mtfe_pkg::*;

   // Exactly one flag is set, so OR-ing the indices of set flags gives the position.
   always_comb begin
      rank = '0;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         if (match_vec[i]) begin
            rank = rank | IDX_W'(i);
         end
      end
   end

endmodule
